/* rtl/core/rdf_pkg.sv */
// rdf_pkg: word types, mode codes, character constants and the digit-to-ascii
// function shared by the radix digit formatter modules
// no dependencies
package rdf_pkg;

   localparam int FIELD_BITS = 31;

   localparam logic [1:0] MODE_BIN = 2'd0;
   localparam logic [1:0] MODE_OCT = 2'd1;
   localparam logic [1:0] MODE_HEX = 2'd2;
   localparam logic [1:0] MODE_BCD = 2'd3;

   localparam logic [6:0] CHAR_ZERO = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [3:0] DEC_RADIX = 4'd10;

   typedef struct packed {
      logic [FIELD_BITS-1:0] value;
      logic [1:0]            action;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_value;
      logic [6:0] digit_char;
      logic       last_digit;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic dabble;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_bcd;
      logic cnt_zero;
      logic digit_zero;
   } status_type;

   function automatic logic [6:0] digit_char_of(input logic [3:0] d);
      logic [6:0] c;
      if (d < DEC_RADIX) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_UPPER_A + {3'b000, d - DEC_RADIX};
      end
      return c;
   endfunction

endpackage

/* rtl/core/rdf_ctrl.sv */
// rdf_ctrl: sequencing state machine of the radix digit formatter
// depends on rdf_pkg (cmd_type, status_type)
module rdf_ctrl
   import rdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.is_bcd ? ST_CONVERT : ST_SCAN;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // skip leading zero digits, keep the least significant one
            if (!status.digit_zero || status.cnt_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/rdf_datapath.sv */
// rdf_datapath: value register, shift-add-3 bcd register, digit counter,
// digit select and registered result word
// depends on rdf_pkg (req_type, rsp_type, cmd_type, status_type)
module rdf_datapath
   import rdf_pkg::*;
#(
   parameter int VALUE_BITS     = 31,
   parameter int DECIMAL_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_word
);

   localparam int EFF_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int CNT_MAX  = (EFF_BITS > DECIMAL_DIGITS) ? EFF_BITS : DECIMAL_DIGITS;
   localparam int CNT_W    = $clog2(CNT_MAX);
   localparam int DIG_IW   = $clog2(DECIMAL_DIGITS);

   localparam logic [FIELD_BITS-1:0] VAL_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - EFF_BITS);

   localparam logic [CNT_W-1:0] TOP_BIN = CNT_W'(EFF_BITS - 1);
   localparam logic [CNT_W-1:0] TOP_OCT = CNT_W'((EFF_BITS + 2) / 3 - 1);
   localparam logic [CNT_W-1:0] TOP_HEX = CNT_W'((EFF_BITS + 3) / 4 - 1);
   localparam logic [CNT_W-1:0] TOP_BCD = CNT_W'(DECIMAL_DIGITS - 1);

   logic [FIELD_BITS-1:0]           work_ff, work_in;
   logic [1:0]                      mode_ff, mode_in;
   logic [DECIMAL_DIGITS-1:0][3:0]  bcd_ff, bcd_in;
   logic [DECIMAL_DIGITS-1:0][3:0]  bcd_adj;
   logic [DECIMAL_DIGITS*4-1:0]     bcd_flat;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_type                         rsp_ff, rsp_in;

   logic [CNT_W+1:0]      sh_amt;
   logic [FIELD_BITS-1:0] shifted;
   logic [3:0]            dmask;
   logic [3:0]            digit;
   logic [CNT_W-1:0]      load_top;

   // add 3 to every bcd digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DECIMAL_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   assign bcd_flat = bcd_adj;

   // digit group select for the power-of-two radixes
   always_comb begin
      case (mode_ff)
         MODE_BIN: begin
            sh_amt = {2'b00, cnt_ff};
            dmask  = 4'h1;
         end
         MODE_OCT: begin
            sh_amt = {2'b00, cnt_ff} + {1'b0, cnt_ff, 1'b0};
            dmask  = 4'h7;
         end
         MODE_HEX: begin
            sh_amt = {cnt_ff, 2'b00};
            dmask  = 4'hF;
         end
         default: begin
            sh_amt = '0;
            dmask  = 4'hF;
         end
      endcase
   end

   assign shifted = work_ff >> sh_amt;
   assign digit   = (mode_ff == MODE_BCD) ? bcd_ff[cnt_ff[DIG_IW-1:0]]
                                          : (shifted[3:0] & dmask);

   always_comb begin
      case (req_word.action)
         MODE_BIN: load_top = TOP_BIN;
         MODE_OCT: load_top = TOP_OCT;
         MODE_HEX: load_top = TOP_HEX;
         // bcd: one shift per kept value bit
         default:  load_top = TOP_BIN;
      endcase
   end

   always_comb begin
      work_in      = work_ff;
      mode_in      = mode_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (cmd.load) begin
         work_in = req_word.value & VAL_MASK;
         mode_in = req_word.action;
         bcd_in  = '0;
         cnt_in  = load_top;
      end
      if (cmd.dabble) begin
         bcd_in  = {bcd_flat[DECIMAL_DIGITS*4-2:0], work_ff[EFF_BITS-1]};
         work_in = work_ff << 1;
         cnt_in  = (cnt_ff == '0) ? TOP_BCD : cnt_ff - 1'b1;
      end
      if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.digit_value    = digit;
         rsp_in.digit_char     = digit_char_of(digit);
         rsp_in.last_digit     = (cnt_ff == '0);
      end
   end

   assign status.is_bcd     = (req_word.action == MODE_BCD);
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.digit_zero = (digit == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      mode_ff <= mode_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* rtl/core/radix_digit_formatter.sv */
// radix_digit_formatter: top level, controller plus datapath
// depends on rdf_pkg, rdf_ctrl, rdf_datapath
// sequence: binary/octal/hex scan past the z leading zero digits, then emit n digits;
//   bcd first shifts in every kept value bit through the shift-add-3 convert loop
// first digit strobes once the scan ends (bcd: after the convert loop too), then one per cycle
// throughput: one word at a time, busy stays high until the last digit is issued
// reset: synchronous active-high reset idles the controller and clears the strobe
module radix_digit_formatter
   import rdf_pkg::*;
#(
   parameter int VALUE_BITS     = 31,
   parameter int DECIMAL_DIGITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   // request word, taken when start is high and busy is low
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   // result word, one digit per strobe, no back pressure
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   cmd_type    cmd;
   status_type status;

   // sequencer: load, convert (bcd only), skip leading zeros, emit digits
   rdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // value and bcd registers, digit counter, registered result
   rdf_datapath #(
      .VALUE_BITS     (VALUE_BITS),
      .DECIMAL_DIGITS (DECIMAL_DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* tb/radix_digit_formatter_tb.sv */
// radix_digit_formatter_tb: self-checking bench for the radix digit formatter,
// random and directed words in all four modes, digits checked against a predictor
// depends on rdf_pkg and radix_digit_formatter
module radix_digit_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rdf_pkg::*;

   localparam int VALUE_BITS     = 31;
   localparam int DECIMAL_DIGITS = 10;
   localparam int KEPT_BITS      = VALUE_BITS < FIELD_BITS ? VALUE_BITS : FIELD_BITS;
   localparam logic [FIELD_BITS-1:0] VALUE_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - KEPT_BITS);
   localparam int RANDOM_WORDS   = 98;
   // a stretch of back-to-back requests with no idle cycles at all
   localparam int BURST_FIRST    = 40;
   localparam int BURST_LAST     = 69;
   localparam int DRAIN_CYCLES   = 40;

   // digit predictor and ordered store of the digits still owed by the block
   class digit_ledger;
      rsp_type               owed_digits[$];
      int unsigned           fault_count;

      function new();
         fault_count = 0;
      endfunction

      // works out the digit sequence of one accepted request word
      function void note_request(input req_type word);
         logic [FIELD_BITS-1:0] rest;
         logic [3:0]            msd_first[$];
         logic [3:0]            decimal[DECIMAL_DIGITS];
         logic [3:0]            d;
         int                    top;
         int                    group_bits;
         rsp_type               digit;
         rest       = word.value & VALUE_MASK;
         if (word.action == MODE_BCD) begin
            // low DECIMAL_DIGITS decimal digits, leading zeros dropped
            top = 0;
            for (int i = 0; i < DECIMAL_DIGITS; i++) begin
               decimal[i] = 4'(rest % DEC_RADIX);
               rest       = rest / DEC_RADIX;
               if (decimal[i] != 0) top = i;
            end
            for (int i = top; i >= 0; i--) msd_first.push_back(decimal[i]);
         end else begin
            group_bits = (word.action == MODE_BIN) ? 1 : (word.action == MODE_OCT) ? 3 : 4;
            do begin
               msd_first.push_front(4'(rest & ((1 << group_bits) - 1)));
               rest = rest >> group_bits;
            end while (rest != 0);
         end
         foreach (msd_first[k]) begin
            d                 = msd_first[k];
            digit.digit_value = d;
            digit.digit_char  = (d < DEC_RADIX) ? CHAR_ZERO + d : CHAR_UPPER_A + (d - DEC_RADIX);
            digit.last_digit  = (k == msd_first.size() - 1);
            owed_digits.push_back(digit);
         end
      endfunction

      // compares one strobed digit word with the oldest owed digit
      function void check_digit(input rsp_type got);
         rsp_type want;
         if (owed_digits.size() == 0) begin
            $display("%0t: digit word %h with none expected", $time, got);
            fault_count++;
            return;
         end
         want = owed_digits.pop_front();
         if (got.digit_value !== want.digit_value) begin
            $display("%0t: digit_value expected %h actual %h", $time,
                     want.digit_value, got.digit_value);
            fault_count++;
         end
         if (got.digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %h actual %h", $time,
                     want.digit_char, got.digit_char);
            fault_count++;
         end
         if (got.last_digit !== want.last_digit) begin
            $display("%0t: last_digit expected %b actual %b", $time,
                     want.last_digit, got.last_digit);
            fault_count++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   digit_ledger ledger = new();

   radix_digit_formatter #(
      .VALUE_BITS    (VALUE_BITS),
      .DECIMAL_DIGITS(DECIMAL_DIGITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // results cannot be held off, so every strobe is checked in the cycle it shows
   // sampled mid-cycle so the check never races the block's own edge
   always @(negedge clock) begin
      if (!reset && rsp_valid) ledger.check_digit(rsp_word);
   end

   // offers one request word, maybe after a random idle gap, and returns at the
   // rising edge that takes it; called and returning in a rising edge time step
   task automatic issue_word(input logic [FIELD_BITS-1:0] value, input logic [1:0] mode,
                             input bit may_idle);
      req_type word;
      int      gap;
      word.value  = value;
      word.action = mode;
      if (may_idle && $urandom_range(0, 99) < 38) begin
         // mostly short gaps, now and then one long enough to span a whole conversion
         gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // start stays high from the previous word when there is no gap
      start    <= 1'b1;
      req_word <= word;
      // busy seen low mid-cycle means the coming edge takes the word
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      ledger.note_request(word);
   endtask

   // random value: full width, small, random length, or decimal with inner zeros
   function automatic logic [FIELD_BITS-1:0] pick_value();
      logic [FIELD_BITS-1:0] v;
      int unsigned           decade;
      int unsigned           power;
      case ($urandom_range(0, 3))
         0: v = FIELD_BITS'($urandom);
         1: v = FIELD_BITS'($urandom_range(0, 255));
         2: v = FIELD_BITS'($urandom >> $urandom_range(1, 31));
         default: begin
            decade = $urandom_range(0, 9);
            power  = 1;
            repeat (decade) power = power * 10;
            v = FIELD_BITS'(power * $urandom_range(1, (decade == 9) ? 2 : 9)
                            + $urandom_range(0, 1));
         end
      endcase
      return v & VALUE_MASK;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero gives a lone '0' in every mode
      issue_word('0, MODE_BIN, 1'b1);
      issue_word('0, MODE_OCT, 1'b1);
      issue_word('0, MODE_HEX, 1'b1);
      issue_word('0, MODE_BCD, 1'b1);
      // largest value: 31 binary digits, 11 octal, 8 hex, 10 decimal
      issue_word(VALUE_MASK, MODE_BIN, 1'b1);
      issue_word(VALUE_MASK, MODE_OCT, 1'b1);
      issue_word(VALUE_MASK, MODE_HEX, 1'b1);
      issue_word(VALUE_MASK, MODE_BCD, 1'b1);
      // single digit runs
      issue_word(31'd1, MODE_BIN, 1'b0);
      issue_word(31'd7, MODE_OCT, 1'b0);
      issue_word(31'd15, MODE_HEX, 1'b0);
      issue_word(31'd9, MODE_BCD, 1'b0);
      // digit boundaries and hex letters
      issue_word(31'h4000_0000, MODE_BIN, 1'b1);
      issue_word(31'd8, MODE_OCT, 1'b1);
      issue_word(31'h10, MODE_HEX, 1'b1);
      issue_word(31'h0ABC_DEF9, MODE_HEX, 1'b1);
      issue_word(31'h5555_5555, MODE_BIN, 1'b1);
      issue_word(31'h2AAA_AAAA, MODE_OCT, 1'b1);
      // decimal zeros inside and at the bottom of the run
      issue_word(31'd1000000000, MODE_BCD, 1'b1);
      issue_word(31'd2000000007, MODE_BCD, 1'b1);
      issue_word(31'd10, MODE_BCD, 1'b1);
      issue_word(31'd1234567890, MODE_BCD, 1'b1);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         issue_word(pick_value(), 2'($urandom_range(MODE_BIN, MODE_BCD)),
                    !(n >= BURST_FIRST && n <= BURST_LAST));
      end
      start <= 1'b0;

      // every owed digit in, then a margin for any stray strobe
      while (ledger.owed_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
